FILE: rtl/assert_macros.svh
// assertion helpers for the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define LZWBD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("lzwbd assertion failed");
`define LZWBD_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("lzwbd assertion failed");
`else
`define LZWBD_ASSERT(label, clk, rst, prop)
`define LZWBD_ASSERT_NR(label, clk, prop)
`endif

`endif

FILE: rtl/lzwbd_pkg.sv
`timescale 1ns / 1ps
package lzwbd_pkg;

   localparam int DICT_ENTRIES = 4096;
   localparam int BLOCK_CODES  = 3840;

   localparam logic [11:0] FULL_TOP = 12'd4095;
   localparam logic [11:0] END_CODE = 12'd256;

   localparam logic [2:0] ST_BYTE     = 3'd0;
   localparam logic [2:0] ST_STARVED  = 3'd1;
   localparam logic [2:0] ST_END      = 3'd2;
   localparam logic [2:0] ST_BAD      = 3'd3;
   localparam logic [2:0] ST_ACCEPTED = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;
   localparam logic [2:0] ST_IDLE     = 3'd6;

   localparam logic [1:0] MODE_PUSH = 2'd0;
   localparam logic [1:0] MODE_PULL = 2'd1;
   localparam logic [1:0] MODE_RST  = 2'd2;
   localparam logic [1:0] MODE_RST3 = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [2:0] status;
      logic       string_end;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_PULL,
      OP_RESTART
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CODE,
      B_FP,
      B_FC,
      B_WALK,
      B_WALK2,
      B_POP,
      B_POPD
   } back_state_type;

endpackage

FILE: rtl/lzwbd_front.sv
`timescale 1ns / 1ps
module lzwbd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lzwbd_pkg::req_type req_payload,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output lzwbd_pkg::cmd_type cmd
);
   import lzwbd_pkg::*;

   cmd_type    slot_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic       push, pop;

   always_comb begin
      cls.data_byte = req_payload.data_byte;
      unique case (req_payload.mode) inside
         MODE_PUSH: cls.op = OP_PUSH;
         MODE_PULL: cls.op = OP_PULL;
         MODE_RST, MODE_RST3: cls.op = OP_RESTART;
         default: cls.op = OP_RESTART;
      endcase
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = slot_ff[rp_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= cls;
      end
   end

endmodule

FILE: rtl/lzwbd_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lzwbd_back #(
   parameter int CODE_QUEUE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  lzwbd_pkg::cmd_type cmd,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lzwbd_pkg::rsp_type rsp_payload
);
   import lzwbd_pkg::*;

   localparam int QA = (CODE_QUEUE_DEPTH > 1) ? $clog2(CODE_QUEUE_DEPTH) : 1;
   localparam int QC = $clog2(CODE_QUEUE_DEPTH + 1);

   back_state_type state_ff, state_in;

   logic [19:0] acc_ff, acc_in;
   logic [4:0]  bc_ff, bc_in;
   logic [11:0] blk_ff, blk_in;
   logic [QA-1:0] qhead_ff, qhead_in;
   logic [QC-1:0] qcnt_ff, qcnt_in;
   logic [11:0] top_ff, top_in;
   logic [11:0] prev_ff, prev_in;
   logic [11:0] c_ff, c_in;
   logic [7:0]  fp_ff, fp_in;
   logic [12:0] scnt_ff, scnt_in;
   logic        active_ff, active_in;
   logic        ended_ff, ended_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic [11:0] qmem [CODE_QUEUE_DEPTH];
   logic [11:0] q_rd_ff;
   logic [11:0] pmem [DICT_ENTRIES];
   logic [7:0]  smem [DICT_ENTRIES];
   logic [7:0]  fmem [DICT_ENTRIES];
   logic [7:0]  stk  [DICT_ENTRIES];
   logic [11:0] p_rd_ff;
   logic [7:0]  s_rd_ff, f_rd_ff, stk_rd_ff;

   logic          q_we, q_re, d_we, f_re, ps_re, stk_we, stk_re;
   logic [QA-1:0] q_wa;
   logic [11:0]   q_wd, d_wa, f_ra, ps_ra, stk_wa, stk_ra;
   logic [7:0]    d_ws, d_wf, stk_wd;

   logic          take;
   logic [22:0]   shifted;
   logic [19:0]   acc_or, wmask;
   logic [4:0]    bc8, w;
   logic [QC:0]   qsum;
   logic [11:0]   code, n_top;
   logic [7:0]    fc;

   assign take      = (state_ff == B_IDLE) && cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_ready = (state_ff == B_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign code  = q_rd_ff;
   assign n_top = top_ff + 12'd1;

   always_comb begin
      shifted = {15'd0, cmd.data_byte} << bc_ff[3:0];
      acc_or  = acc_ff | shifted[19:0];
      bc8     = bc_ff + 5'd8;
      if (blk_ff < 12'd256) begin
         w = 5'd9;
      end else if (blk_ff < 12'd768) begin
         w = 5'd10;
      end else if (blk_ff < 12'd1792) begin
         w = 5'd11;
      end else begin
         w = 5'd12;
      end
      wmask = (20'd1 << w) - 20'd1;
      qsum  = {{(QC+1-QA){1'b0}}, qhead_ff} + {1'b0, qcnt_ff};
      if (qsum >= (QC+1)'(CODE_QUEUE_DEPTH)) begin
         qsum = qsum - (QC+1)'(CODE_QUEUE_DEPTH);
      end
      if (code == n_top) begin
         fc = fp_ff;
      end else if (code < 12'd256) begin
         fc = code[7:0];
      end else begin
         fc = f_rd_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (take && cmd.op == OP_PULL && active_ff && !ended_ff) begin
               if (scnt_ff != 13'd0) begin
                  state_in = B_POP;
               end else if (qcnt_ff != '0) begin
                  state_in = B_CODE;
               end
            end
         end
         B_CODE: begin
            if (code == END_CODE) begin
               state_in = B_IDLE;
            end else if (top_ff == FULL_TOP) begin
               state_in = (code > 12'd255) ? B_IDLE : B_WALK;
            end else begin
               state_in = (code > n_top) ? B_IDLE : B_FP;
            end
         end
         B_FP:    state_in = B_FC;
         B_FC:    state_in = B_WALK;
         B_WALK:  state_in = (c_ff > 12'd255) ? B_WALK2 : B_POP;
         B_WALK2: state_in = B_WALK;
         B_POP:   state_in = B_POPD;
         B_POPD:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      bc_in = bc_ff;
      blk_in = blk_ff;
      qhead_in = qhead_ff;
      qcnt_in = qcnt_ff;
      top_in = top_ff;
      prev_in = prev_ff;
      c_in = c_ff;
      fp_in = fp_ff;
      scnt_in = scnt_ff;
      active_in = active_ff;
      ended_in = ended_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      q_we = 1'b0;
      q_wa = qsum[QA-1:0];
      q_wd = 12'(acc_or & wmask);
      q_re = 1'b0;
      d_we = 1'b0;
      d_wa = n_top;
      d_ws = fc;
      d_wf = fp_ff;
      f_re = 1'b0;
      f_ra = prev_ff;
      ps_re = 1'b0;
      ps_ra = c_ff;
      stk_we = 1'b0;
      stk_wa = scnt_ff[11:0];
      stk_wd = c_ff[7:0];
      stk_re = 1'b0;
      stk_ra = 12'(scnt_ff - 13'd1);
      unique case (state_ff)
         B_IDLE: begin
            if (take) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{out_byte: 8'd0, status: ST_ACCEPTED, string_end: 1'b0};
               if (cmd.op == OP_RESTART) begin
                  acc_in = '0;
                  bc_in = '0;
                  blk_in = '0;
                  qhead_in = '0;
                  qcnt_in = '0;
                  top_in = FULL_TOP;
                  prev_in = '0;
                  scnt_in = '0;
                  active_in = 1'b1;
                  ended_in = 1'b0;
               end else if (!active_ff) begin
                  rsp_in.status = ST_IDLE;
               end else if (cmd.op == OP_PUSH) begin
                  if (qcnt_ff == QC'(CODE_QUEUE_DEPTH)) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     acc_in = acc_or;
                     bc_in = bc8;
                     if (bc8 >= w) begin
                        acc_in = acc_or >> w;
                        bc_in = bc8 - w;
                        q_we = 1'b1;
                        qcnt_in = qcnt_ff + QC'(1);
                        blk_in = (blk_ff == 12'(BLOCK_CODES - 1)) ? 12'd0 : blk_ff + 12'd1;
                     end
                  end
               end else if (ended_ff) begin
                  rsp_in.status = ST_END;
               end else if (scnt_ff != 13'd0) begin
                  rsp_valid_in = 1'b0;
               end else if (qcnt_ff == '0) begin
                  rsp_in.status = ST_STARVED;
               end else begin
                  rsp_valid_in = 1'b0;
                  q_re = 1'b1;
                  qcnt_in = qcnt_ff - QC'(1);
                  qhead_in = (qhead_ff == QA'(CODE_QUEUE_DEPTH - 1)) ? '0 : qhead_ff + QA'(1);
               end
            end
         end
         B_CODE: begin
            if (code == END_CODE) begin
               ended_in = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in = '{out_byte: 8'd0, status: ST_END, string_end: 1'b0};
            end else if (top_ff == FULL_TOP) begin
               if (code > 12'd255) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{out_byte: 8'd0, status: ST_BAD, string_end: 1'b0};
               end else begin
                  top_in = END_CODE;
                  prev_in = code;
                  c_in = code;
               end
            end else if (code > n_top) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{out_byte: 8'd0, status: ST_BAD, string_end: 1'b0};
            end else begin
               f_re = 1'b1;
            end
         end
         B_FP: begin
            fp_in = (prev_ff < 12'd256) ? prev_ff[7:0] : f_rd_ff;
            f_re = 1'b1;
            f_ra = code;
         end
         B_FC: begin
            d_we = 1'b1;
            top_in = n_top;
            prev_in = code;
            c_in = code;
         end
         B_WALK: begin
            if (c_ff > 12'd255) begin
               ps_re = 1'b1;
            end else begin
               stk_we = 1'b1;
               scnt_in = scnt_ff + 13'd1;
            end
         end
         B_WALK2: begin
            stk_we = 1'b1;
            stk_wd = s_rd_ff;
            scnt_in = scnt_ff + 13'd1;
            c_in = p_rd_ff;
         end
         B_POP: begin
            stk_re = 1'b1;
            scnt_in = scnt_ff - 13'd1;
         end
         B_POPD: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{out_byte: stk_rd_ff, status: ST_BYTE,
                       string_end: (scnt_ff == 13'd0)};
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         acc_ff <= '0;
         bc_ff <= '0;
         blk_ff <= '0;
         qhead_ff <= '0;
         qcnt_ff <= '0;
         top_ff <= FULL_TOP;
         prev_ff <= '0;
         scnt_ff <= '0;
         active_ff <= 1'b0;
         ended_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in;
         bc_ff <= bc_in;
         blk_ff <= blk_in;
         qhead_ff <= qhead_in;
         qcnt_ff <= qcnt_in;
         top_ff <= top_in;
         prev_ff <= prev_in;
         scnt_ff <= scnt_in;
         active_ff <= active_in;
         ended_ff <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      fp_ff <= fp_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         qmem[q_wa] <= q_wd;
      end
      if (q_re) begin
         q_rd_ff <= qmem[qhead_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         pmem[d_wa] <= prev_ff;
         smem[d_wa] <= d_ws;
      end
      if (ps_re) begin
         p_rd_ff <= pmem[ps_ra];
         s_rd_ff <= smem[ps_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         fmem[d_wa] <= d_wf;
      end
      if (f_re) begin
         f_rd_ff <= fmem[f_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk[stk_wa] <= stk_wd;
      end
      if (stk_re) begin
         stk_rd_ff <= stk[stk_ra];
      end
   end

   `LZWBD_ASSERT(a_stack_bound, clock, reset, scnt_ff <= 13'(DICT_ENTRIES))
   `LZWBD_ASSERT(a_queue_bound, clock, reset, qcnt_ff <= QC'(CODE_QUEUE_DEPTH))
   `LZWBD_ASSERT(a_code_entry, clock, reset, (state_ff == B_CODE) |-> ($past(state_ff) == B_IDLE))
   `LZWBD_ASSERT(a_last_empty, clock, reset, (rsp_valid_ff && rsp_ff.status == ST_BYTE && rsp_ff.string_end) |-> (scnt_ff == 13'd0))

endmodule

FILE: rtl/lzw_block_decoder.sv
`timescale 1ns / 1ps
// 12-bit lzw decoder with push/pull words: mode 0 pushes a compressed byte, mode 1 pulls one
// decoded byte, mode 2 or 3 restarts. a two-word front queue takes words while the back end
// works. push, restart and status-only words are answered from the idle state. a pull served
// from the pending string pops the stack, then answers with the byte; a pull that takes an end
// or bad code answers from the code state. a literal after a dictionary restart goes straight
// onto the stack; any other code first adds a dictionary entry, and the code's prefix chain is
// then walked onto the stack before the first byte is popped. no clearing pass after reset.
module lzw_block_decoder #(
   parameter int CODE_QUEUE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lzwbd_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output lzwbd_pkg::rsp_type rsp_payload
);
   import lzwbd_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;

   lzwbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   lzwbd_back #(
      .CODE_QUEUE_DEPTH (CODE_QUEUE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/lzw_checker.sv
`timescale 1ns / 1ps
module lzw_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  lzwbd_pkg::req_type req_payload,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  lzwbd_pkg::rsp_type rsp_payload,
   output int                 fail_count,
   output int                 words_owed
);
   import lzwbd_pkg::*;

   localparam int QDEPTH = 64;

   logic [11:0] prefix_mem [DICT_ENTRIES];
   logic [7:0]  suffix_mem [DICT_ENTRIES];
   logic [7:0]  first_mem  [DICT_ENTRIES];
   logic [7:0]  str_stack  [DICT_ENTRIES];
   logic [11:0] code_fifo  [QDEPTH];
   int          str_count, top_entry, last_code, acc, acc_bits, block_idx;
   int          fifo_count, fifo_head;
   bit          running, finished;
   rsp_type     owed_q [$];

   assign words_owed = owed_q.size();

   function automatic void clear_decoder(bit act);
      for (int k = 0; k < DICT_ENTRIES; k++) begin
         prefix_mem[k] = '0;
         suffix_mem[k] = (k < 256) ? k[7:0] : 8'd0;
         first_mem[k]  = (k < 256) ? k[7:0] : 8'd0;
         str_stack[k]  = '0;
      end
      for (int k = 0; k < QDEPTH; k++) code_fifo[k] = '0;
      str_count  = 0;
      top_entry  = int'(FULL_TOP);
      last_code  = 0;
      acc        = 0;
      acc_bits   = 0;
      block_idx  = 0;
      fifo_count = 0;
      fifo_head  = 0;
      running    = act;
      finished   = 0;
   endfunction

   function automatic rsp_type word_result(logic [7:0] b, logic [2:0] st, logic e);
      rsp_type r;
      r.out_byte   = b;
      r.status     = st;
      r.string_end = e;
      return r;
   endfunction

   function automatic void unwind_string(int code);
      int c, guard;
      c = code;
      guard = 0;
      str_count = 0;
      while (c > 255 && guard < DICT_ENTRIES && str_count < DICT_ENTRIES) begin
         str_stack[str_count] = suffix_mem[c];
         str_count++;
         c = int'(prefix_mem[c]);
         guard++;
      end
      if (str_count < DICT_ENTRIES) begin
         str_stack[str_count] = c[7:0];
         str_count++;
      end
   endfunction

   function automatic rsp_type decode_word(req_type w);
      int width, code, n;
      if (w.mode[1]) begin
         clear_decoder(1);
         return word_result(8'd0, ST_ACCEPTED, 1'b0);
      end
      if (!running) return word_result(8'd0, ST_IDLE, 1'b0);
      if (w.mode == MODE_PUSH) begin
         if (fifo_count >= QDEPTH) return word_result(8'd0, ST_FULL, 1'b0);
         acc = (acc | (int'(w.data_byte) << (acc_bits & 15))) & 32'hFFFFF;
         acc_bits += 8;
         width = (block_idx < 256) ? 9 : (block_idx < 768) ? 10 :
                 (block_idx < 1792) ? 11 : 12;
         if (acc_bits >= width) begin
            code_fifo[(fifo_head + fifo_count) % QDEPTH] = 12'(acc & ((1 << width) - 1));
            acc = acc >> width;
            acc_bits -= width;
            fifo_count++;
            block_idx = (block_idx + 1 >= BLOCK_CODES) ? 0 : block_idx + 1;
         end
         return word_result(8'd0, ST_ACCEPTED, 1'b0);
      end
      if (finished) return word_result(8'd0, ST_END, 1'b0);
      if (str_count == 0) begin
         if (fifo_count == 0) return word_result(8'd0, ST_STARVED, 1'b0);
         code = int'(code_fifo[fifo_head]);
         fifo_head = (fifo_head + 1) % QDEPTH;
         fifo_count--;
         if (code == END_CODE) begin
            finished = 1;
            return word_result(8'd0, ST_END, 1'b0);
         end
         if (top_entry >= FULL_TOP) begin
            if (code > 255) return word_result(8'd0, ST_BAD, 1'b0);
            top_entry = int'(END_CODE);
         end else begin
            n = top_entry + 1;
            if (code > n) return word_result(8'd0, ST_BAD, 1'b0);
            prefix_mem[n] = 12'(last_code);
            suffix_mem[n] = (code == n) ? first_mem[last_code] : first_mem[code];
            first_mem[n]  = first_mem[last_code];
            top_entry = n;
         end
         last_code = code;
         unwind_string(code);
      end
      str_count--;
      return word_result(str_stack[str_count], ST_BYTE, str_count == 0);
   endfunction

   always @(posedge clock) begin
      rsp_type exp_w;
      if (reset) begin
         clear_decoder(0);
         owed_q.delete();
         fail_count = 0;
      end else begin
         if (req_valid && req_ready) owed_q.push_back(decode_word(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               $error("unexpected word: %p", rsp_payload);
               fail_count++;
            end else begin
               exp_w = owed_q.pop_front();
               if (rsp_payload.out_byte !== exp_w.out_byte) begin
                  $error("out_byte expected %0d got %0d", exp_w.out_byte, rsp_payload.out_byte);
                  fail_count++;
               end
               if (rsp_payload.status !== exp_w.status) begin
                  $error("status expected %0d got %0d", exp_w.status, rsp_payload.status);
                  fail_count++;
               end
               if (rsp_payload.string_end !== exp_w.string_end) begin
                  $error("string_end expected %0d got %0d", exp_w.string_end,
                         rsp_payload.string_end);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   import lzwbd_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic    clock, reset, req_valid, req_ready, rsp_valid, rsp_ready;
   req_type req_payload;
   rsp_type rsp_payload;
   int      fail_count, words_owed, cycles;
   int      burst_left, stall_pct, hold_left;
   bit      gaps_on, hold_req;

   // stream builder state
   int      enc_acc, enc_bits, enc_idx, enc_top, enc_last, pulls_due;
   int      str_len [DICT_ENTRIES];

   lzw_block_decoder u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   lzw_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .fail_count(fail_count), .words_owed(words_owed)
   );

   always begin
      clock = 1'b0; #2;
      clock = 1'b1; #2;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (cycles % 700 == 0) stall_pct <= $urandom_range(0, 2) * 35;
      if (hold_req) begin
         hold_req = 0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   task automatic send_word(logic [1:0] m, logic [7:0] d);
      int gap;
      bit seen;
      if (gaps_on && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 20);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_payload <= {m, d};
      // ready is sampled ahead of the edge it applies to
      do begin
         @(negedge clock);
         seen = req_ready;
         @(posedge clock);
      end while (!seen);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_owed != 0) @(posedge clock);
   endtask

   task automatic restart_stream(logic [1:0] m);
      send_word(m, 8'($urandom));
      enc_acc = 0;
      enc_bits = 0;
      enc_idx = 0;
      enc_top = FULL_TOP;
      enc_last = 0;
      pulls_due = 0;
      for (int k = 0; k < 256; k++) str_len[k] = 1;
   endtask

   task automatic pull_words(int n);
      repeat (n) send_word(MODE_PULL, 8'($urandom));
   endtask

   task automatic put_code(int c);
      int width, len;
      width = (enc_idx < 256) ? 9 : (enc_idx < 768) ? 10 : (enc_idx < 1792) ? 11 : 12;
      enc_idx = (enc_idx + 1 >= BLOCK_CODES) ? 0 : enc_idx + 1;
      enc_acc |= (c & ((1 << width) - 1)) << enc_bits;
      enc_bits += width;
      len = 1;
      if (c != END_CODE) begin
         if (enc_top == FULL_TOP) begin
            if (c <= 255) begin
               enc_top = END_CODE;
               enc_last = c;
            end
         end else if (c <= enc_top + 1) begin
            str_len[enc_top + 1] = str_len[enc_last] + 1;
            enc_top++;
            enc_last = c;
            len = str_len[c];
         end
      end
      while (enc_bits >= 8) begin
         send_word(MODE_PUSH, enc_acc[7:0]);
         enc_acc >>= 8;
         enc_bits -= 8;
      end
      pull_words(pulls_due);
      pulls_due = len;
   endtask

   task automatic close_stream();
      put_code(END_CODE);
      if (enc_bits > 0) send_word(MODE_PUSH, enc_acc[7:0]);
      enc_bits = 0;
      pull_words(pulls_due + $urandom_range(1, 3));
      pulls_due = 0;
   endtask

   function automatic int pick_code(int lit_pct, int noise_pct);
      int r;
      if (enc_top == FULL_TOP) return $urandom_range(0, 255);
      r = $urandom_range(0, 99);
      if (r < noise_pct && enc_top < 4094) return $urandom_range(enc_top + 2, 4095);
      if (r < lit_pct) return $urandom_range(0, 255);
      if (r < lit_pct + 10 || enc_top < 257) return enc_top + 1;
      return $urandom_range(257, enc_top);
   endfunction

   task automatic run_stream(int ncodes, int lit_pct, int noise_pct);
      restart_stream(MODE_RST);
      repeat (ncodes) begin
         put_code(pick_code(lit_pct, noise_pct));
         if ($urandom_range(0, 99) < noise_pct) begin
            if ($urandom_range(0, 1)) send_word(MODE_PUSH, 8'($urandom));
            else send_word(MODE_PULL, 8'($urandom));
         end
      end
      close_stream();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      cycles = 0;
      stall_pct = 0;
      hold_left = 0;
      hold_req = 0;
      burst_left = 0;
      gaps_on = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // not started, then literal-due bad code, kwkwk, extremes, end
      send_word(MODE_PUSH, 8'hFF);
      send_word(MODE_PULL, 8'h00);
      restart_stream(MODE_RST);
      send_word(MODE_PULL, 8'h00);
      put_code(300);
      put_code(255);
      put_code(0);
      put_code(258);
      put_code(257);
      put_code(4095);
      close_stream();
      send_word(MODE_PUSH, 8'h00);
      send_word(MODE_PULL, 8'hFF);
      // queue full
      restart_stream(MODE_RST3);
      repeat (80) send_word(MODE_PUSH, 8'hFF);
      drain();

      gaps_on = 1;
      repeat (4) run_stream($urandom_range(20, 60), 40, 4);
      drain();

      // long hold-off on the result side while words keep coming
      hold_req = 1;
      run_stream(60, 50, 0);
      drain();

      // mostly literal stream, then noisy ones
      run_stream(60, 85, 0);
      repeat (2) run_stream($urandom_range(20, 60), 30, 10);

      req_valid <= 1'b0;
      while (words_owed != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
